### rtl/rac_pkg.sv
// rac_pkg: shared types for the register ALU block.
// Holds the ALU operation codes and the request/response structs between
// the top-level sequencer and the iterative ALU. No dependencies.
`default_nettype none

package rac_pkg;

    // Register index width on the instruction ports
    localparam int IDX_W = 4;

    typedef enum logic [3:0] {
        ALU_MOV,
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV,
        ALU_AND,
        ALU_OR,
        ALU_XOR,
        ALU_NOT,
        ALU_INC,
        ALU_DEC
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic done;
        logic div_zero;
    } alu_rsp_t;

endpackage

`default_nettype wire

### rtl/rac_regfile.sv
// rac_regfile: general-purpose register file, two registered read ports, one write port.
// Per-entry valid bits make every register read as zero after reset.
// Depends on rac_pkg.
`default_nettype none

module rac_regfile #(
    parameter int NUM_REGISTERS = 10,
    parameter int DATA_WIDTH    = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        rd_en,
    input  wire logic [rac_pkg::IDX_W-1:0]   rd_addr_a,
    input  wire logic [rac_pkg::IDX_W-1:0]   rd_addr_b,
    output logic      [DATA_WIDTH-1:0]       rd_data_a,
    output logic      [DATA_WIDTH-1:0]       rd_data_b,
    input  wire logic                        wr_en,
    input  wire logic [rac_pkg::IDX_W-1:0]   wr_addr,
    input  wire logic [DATA_WIDTH-1:0]       wr_data
);

    localparam int IW = $clog2(NUM_REGISTERS);
    localparam logic [rac_pkg::IDX_W:0] NUM_IDX = (rac_pkg::IDX_W+1)'(NUM_REGISTERS);

    logic [DATA_WIDTH-1:0]    mem [NUM_REGISTERS];
    logic [NUM_REGISTERS-1:0] valid_reg;
    logic [DATA_WIDTH-1:0]    raw_a_reg;
    logic [DATA_WIDTH-1:0]    raw_b_reg;
    logic                     ok_a_reg;
    logic                     ok_b_reg;
    logic                     in_a;
    logic                     in_b;
    logic                     in_w;

    assign in_a = {1'b0, rd_addr_a} < NUM_IDX;
    assign in_b = {1'b0, rd_addr_b} < NUM_IDX;
    assign in_w = {1'b0, wr_addr} < NUM_IDX;

    always_ff @(posedge clk)
    begin
        if (wr_en && in_w)
        begin
            mem[wr_addr[IW-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            raw_a_reg <= mem[rd_addr_a[IW-1:0]];
            raw_b_reg <= mem[rd_addr_b[IW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            ok_a_reg  <= 1'b0;
            ok_b_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en && in_w)
            begin
                valid_reg[wr_addr[IW-1:0]] <= 1'b1;
            end
            if (rd_en)
            begin
                ok_a_reg <= in_a && valid_reg[rd_addr_a[IW-1:0]];
                ok_b_reg <= in_b && valid_reg[rd_addr_b[IW-1:0]];
            end
        end
    end

    // never-written or out-of-range registers read as zero
    assign rd_data_a = ok_a_reg ? raw_a_reg : '0;
    assign rd_data_b = ok_b_reg ? raw_b_reg : '0;

endmodule

`default_nettype wire

### rtl/rac_alu.sv
// rac_alu: iterative ALU built around one shared adder.
// Logic/add ops finish straight from idle, shift-add multiply, restoring signed divide.
// Depends on rac_pkg.
`default_nettype none

module rac_alu #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire rac_pkg::alu_req_t     req,
    input  wire logic [DATA_WIDTH-1:0] a,
    input  wire logic [DATA_WIDTH-1:0] b,
    output rac_pkg::alu_rsp_t          rsp,
    output logic      [DATA_WIDTH-1:0] result
);

    localparam int CNT_W = $clog2(DATA_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

    typedef enum logic [2:0] {
        U_IDLE,
        U_NEG_A,
        U_NEG_B,
        U_MUL,
        U_DIV,
        U_NEG_Q
    } ustate_t;

    ustate_t               state_reg;
    logic [DATA_WIDTH-1:0] acc_reg;    // product / dividend-quotient
    logic [DATA_WIDTH-1:0] aux_reg;    // multiplicand / remainder
    logic [DATA_WIDTH-1:0] opb_reg;    // multiplier / divisor
    logic [CNT_W-1:0]      cnt_reg;
    logic                  sa_reg;
    logic                  sb_reg;
    logic [DATA_WIDTH-1:0] result_reg;
    logic                  done_reg;
    logic                  dz_reg;

    logic [DATA_WIDTH-1:0] add_x;
    logic [DATA_WIDTH-1:0] add_y;
    logic                  add_c;
    logic [DATA_WIDTH:0]   sum;
    logic [DATA_WIDTH-1:0] rem_sh;
    logic [DATA_WIDTH-1:0] simple;
    logic                  last;

    assign rem_sh = {aux_reg[DATA_WIDTH-2:0], acc_reg[DATA_WIDTH-1]};
    assign last   = cnt_reg == CNT_LAST;

    // operand select for the shared adder
    always_comb
    begin
        add_x = a;
        add_y = b;
        add_c = 1'b0;
        unique case (state_reg)
            U_IDLE:
            begin
                case (req.op)
                    rac_pkg::ALU_SUB: begin add_y = ~b; add_c = 1'b1; end
                    rac_pkg::ALU_INC: begin add_y = '0; add_c = 1'b1; end
                    rac_pkg::ALU_DEC: begin add_y = '1; end
                    default:          begin add_y = b; end
                endcase
            end
            U_NEG_A: begin add_x = '0; add_y = ~acc_reg; add_c = 1'b1; end
            U_NEG_B: begin add_x = '0; add_y = ~opb_reg; add_c = 1'b1; end
            U_MUL:   begin add_x = acc_reg; add_y = aux_reg; end
            U_DIV:   begin add_x = rem_sh; add_y = ~opb_reg; add_c = 1'b1; end
            U_NEG_Q: begin add_x = '0; add_y = ~acc_reg; add_c = 1'b1; end
            default: begin add_x = a; end
        endcase
    end

    assign sum = {1'b0, add_x} + {1'b0, add_y} + (DATA_WIDTH+1)'(add_c);

    always_comb
    begin
        case (req.op) inside
            rac_pkg::ALU_ADD,
            rac_pkg::ALU_SUB,
            rac_pkg::ALU_INC,
            rac_pkg::ALU_DEC: simple = sum[DATA_WIDTH-1:0];
            rac_pkg::ALU_AND: simple = a & b;
            rac_pkg::ALU_OR:  simple = a | b;
            rac_pkg::ALU_XOR: simple = a ^ b;
            rac_pkg::ALU_NOT: simple = ~a;
            default:          simple = b;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= U_IDLE;
            done_reg   <= 1'b0;
            dz_reg     <= 1'b0;
            acc_reg    <= '0;
            aux_reg    <= '0;
            opb_reg    <= '0;
            cnt_reg    <= '0;
            sa_reg     <= 1'b0;
            sb_reg     <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                U_IDLE:
                begin
                    if (req.start)
                    begin
                        dz_reg  <= 1'b0;
                        cnt_reg <= '0;
                        if (req.op == rac_pkg::ALU_MUL)
                        begin
                            acc_reg   <= '0;
                            aux_reg   <= a;
                            opb_reg   <= b;
                            state_reg <= U_MUL;
                        end
                        else if (req.op == rac_pkg::ALU_DIV)
                        begin
                            if (b == '0)
                            begin
                                dz_reg   <= 1'b1;
                                done_reg <= 1'b1;
                            end
                            else
                            begin
                                acc_reg   <= a;
                                opb_reg   <= b;
                                sa_reg    <= a[DATA_WIDTH-1];
                                sb_reg    <= b[DATA_WIDTH-1];
                                state_reg <= U_NEG_A;
                            end
                        end
                        else
                        begin
                            result_reg <= simple;
                            done_reg   <= 1'b1;
                        end
                    end
                end
                U_NEG_A:
                begin
                    if (sa_reg)
                    begin
                        acc_reg <= sum[DATA_WIDTH-1:0];
                    end
                    state_reg <= U_NEG_B;
                end
                U_NEG_B:
                begin
                    if (sb_reg)
                    begin
                        opb_reg <= sum[DATA_WIDTH-1:0];
                    end
                    aux_reg   <= '0;
                    state_reg <= U_DIV;
                end
                U_MUL:
                begin
                    if (opb_reg[0])
                    begin
                        acc_reg <= sum[DATA_WIDTH-1:0];
                    end
                    aux_reg <= {aux_reg[DATA_WIDTH-2:0], 1'b0};
                    opb_reg <= {1'b0, opb_reg[DATA_WIDTH-1:1]};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (last)
                    begin
                        result_reg <= opb_reg[0] ? sum[DATA_WIDTH-1:0] : acc_reg;
                        done_reg   <= 1'b1;
                        state_reg  <= U_IDLE;
                    end
                end
                U_DIV:
                begin
                    // carry out means shifted remainder >= divisor
                    acc_reg <= {acc_reg[DATA_WIDTH-2:0], sum[DATA_WIDTH]};
                    aux_reg <= sum[DATA_WIDTH] ? sum[DATA_WIDTH-1:0] : rem_sh;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (last)
                    begin
                        state_reg <= U_NEG_Q;
                    end
                end
                U_NEG_Q:
                begin
                    result_reg <= (sa_reg ^ sb_reg) ? sum[DATA_WIDTH-1:0] : acc_reg;
                    done_reg   <= 1'b1;
                    state_reg  <= U_IDLE;
                end
                default:
                begin
                    state_reg <= U_IDLE;
                end
            endcase
        end
    end

    // response fields in struct order: done, div_zero
    assign rsp    = {done_reg, dz_reg};
    assign result = result_reg;

endmodule

`default_nettype wire

### rtl/register_alu_with_compare_branch.sv
// register_alu_with_compare_branch: two-operand register ALU with compare flag
// and conditional branch resolution. Uses rac_pkg, rac_regfile and rac_alu.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one decoded instruction per
//   transaction: opcode, dest_index, use_immediate, source_index,
//   immediate_value, jump_target. Output channel (out_valid/out_ready)
//   returns exactly one result transaction per instruction, in order.
//   in_ready is high only while the sequencer is idle; one instruction is
//   in flight at a time, since each depends on registers and the flag that
//   the previous one left.
//   From accept to out_valid, jumps and unknown opcodes finish in S_EXEC;
//   MOV/ADD/SUB/logic/CMP/NOT/INC/DEC also pass S_WAIT for the ALU, as do
//   MUL (shift-add, one multiplier bit per cycle) and DIV (two sign fixups,
//   one quotient bit per cycle, result fixup); a zero divisor skips the
//   divide steps. The next instruction is taken the cycle after the result
//   is loaded. Every ALU step uses the one shared adder.
//   The result sits in an output register: a stalled receiver does not stop
//   the next instruction from being accepted and executed; only the
//   completion of that next one waits for the output slot.
//   Reset (rst_n, asynchronous) clears the state machine, all registers
//   (valid bits, so every register reads as zero), the flag and out_valid.
`default_nettype none

module register_alu_with_compare_branch #(
    parameter int NUM_REGISTERS = 10,
    parameter int DATA_WIDTH    = 32,
    parameter int ADDRESS_WIDTH = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // instruction channel
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [4:0]                opcode,
    input  wire logic [3:0]                dest_index,
    input  wire logic                      use_immediate,
    input  wire logic [3:0]                source_index,
    input  wire logic signed [31:0]        immediate_value,
    input  wire logic [15:0]               jump_target,
    // result channel
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic                           dest_written,
    output logic signed [31:0]             dest_result,
    output logic signed [31:0]             flag_result,
    output logic                           branch_taken,
    output logic [15:0]                    branch_address,
    output logic                           divide_error
);

    // opcode encoding on the instruction port
    typedef enum logic [4:0] {
        OP_MOV = 5'd0,
        OP_ADD = 5'd1,
        OP_SUB = 5'd2,
        OP_MUL = 5'd3,
        OP_DIV = 5'd4,
        OP_AND = 5'd5,
        OP_OR  = 5'd6,
        OP_XOR = 5'd7,
        OP_CMP = 5'd8,
        OP_NOT = 5'd9,
        OP_INC = 5'd10,
        OP_DEC = 5'd11,
        OP_JE  = 5'd12,
        OP_JNE = 5'd13,
        OP_JG  = 5'd14,
        OP_JGE = 5'd15,
        OP_JL  = 5'd16,
        OP_JLE = 5'd17
    } opcode_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,     // operands valid from the register file, issue to ALU
        S_WAIT,     // ALU busy
        S_DONE      // committed, waiting for the output slot
    } state_t;

    // branch target mask for narrow program counters
    localparam logic [15:0] ADDR_MASK = (ADDRESS_WIDTH >= 16) ? 16'hFFFF :
                                        16'((32'd1 << ADDRESS_WIDTH) - 32'd1);
    localparam logic [rac_pkg::IDX_W:0] NUM_IDX = (rac_pkg::IDX_W+1)'(NUM_REGISTERS);

    state_t                      state_reg;
    logic [4:0]                  op_reg;
    logic [3:0]                  dest_reg;
    logic                        use_imm_reg;
    logic signed [31:0]          imm_reg;
    logic [15:0]                 tgt_reg;
    logic [DATA_WIDTH-1:0]       flag_reg;

    logic                        out_valid_reg;
    logic                        dest_written_reg;
    logic [31:0]                 dest_result_reg;
    logic [31:0]                 flag_result_reg;
    logic                        branch_taken_reg;
    logic [15:0]                 branch_address_reg;
    logic                        divide_error_reg;

    logic [DATA_WIDTH-1:0]       rd_a;
    logic [DATA_WIDTH-1:0]       rd_b;
    logic [DATA_WIDTH-1:0]       opnd_b;
    logic [DATA_WIDTH-1:0]       alu_result;
    rac_pkg::alu_req_t           alu_req;
    rac_pkg::alu_rsp_t           alu_rsp;

    logic                        accept;
    logic                        uses_unit;
    logic                        is_write;
    logic                        is_cmp;
    logic                        is_div;
    logic                        taken;
    logic                        flag_zero;
    logic                        flag_neg;
    logic                        dest_ok;
    logic                        wr_now;
    logic                        finish;
    logic                        slot_free;
    logic [DATA_WIDTH-1:0]       flag_new;

    assign accept    = in_valid && in_ready;
    assign flag_zero = flag_reg == '0;
    assign flag_neg  = flag_reg[DATA_WIDTH-1];
    assign dest_ok   = {1'b0, dest_reg} < NUM_IDX;

    // immediate is sign-extended (or truncated) to the datapath width
    assign opnd_b = use_imm_reg ? DATA_WIDTH'(imm_reg) : rd_b;

    // instruction decode
    always_comb
    begin
        alu_req.op = rac_pkg::ALU_MOV;
        uses_unit  = 1'b1;
        is_write   = 1'b1;
        is_cmp     = 1'b0;
        is_div     = 1'b0;
        taken      = 1'b0;
        unique case (op_reg) inside
            OP_MOV: alu_req.op = rac_pkg::ALU_MOV;
            OP_ADD: alu_req.op = rac_pkg::ALU_ADD;
            OP_SUB: alu_req.op = rac_pkg::ALU_SUB;
            OP_MUL: alu_req.op = rac_pkg::ALU_MUL;
            OP_DIV:
            begin
                alu_req.op = rac_pkg::ALU_DIV;
                is_div     = 1'b1;
            end
            OP_AND: alu_req.op = rac_pkg::ALU_AND;
            OP_OR:  alu_req.op = rac_pkg::ALU_OR;
            OP_XOR: alu_req.op = rac_pkg::ALU_XOR;
            OP_CMP:
            begin
                alu_req.op = rac_pkg::ALU_SUB;
                is_write   = 1'b0;
                is_cmp     = 1'b1;
            end
            OP_NOT: alu_req.op = rac_pkg::ALU_NOT;
            OP_INC: alu_req.op = rac_pkg::ALU_INC;
            OP_DEC: alu_req.op = rac_pkg::ALU_DEC;
            OP_JE, OP_JNE, OP_JG, OP_JGE, OP_JL, OP_JLE:
            begin
                uses_unit = 1'b0;
                is_write  = 1'b0;
                case (op_reg)
                    OP_JE:   taken = flag_zero;
                    OP_JNE:  taken = !flag_zero;
                    OP_JG:   taken = !flag_zero && !flag_neg;
                    OP_JGE:  taken = !flag_neg;
                    OP_JL:   taken = flag_neg;
                    default: taken = flag_zero || flag_neg;
                endcase
            end
            default:
            begin
                // unknown opcode: no operation
                uses_unit = 1'b0;
                is_write  = 1'b0;
            end
        endcase
        alu_req.start = (state_reg == S_EXEC) && uses_unit;
    end

    assign finish    = ((state_reg == S_EXEC) && !uses_unit) ||
                       ((state_reg == S_WAIT) && alu_rsp.done);
    assign slot_free = !out_valid_reg || out_ready;

    // a zero divisor leaves the destination untouched
    assign wr_now   = is_write && dest_ok && !(is_div && alu_rsp.div_zero);
    assign flag_new = is_cmp ? alu_result : flag_reg;

    rac_regfile #(
        .NUM_REGISTERS (NUM_REGISTERS),
        .DATA_WIDTH    (DATA_WIDTH)
    ) u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_addr_a (dest_index),
        .rd_addr_b (source_index),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b),
        .wr_en     (finish && wr_now),
        .wr_addr   (dest_reg),
        .wr_data   (alu_result)
    );

    rac_alu #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a      (rd_a),
        .b      (opnd_b),
        .rsp    (alu_rsp),
        .result (alu_result)
    );

    // sequencer, flag and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            op_reg             <= '0;
            dest_reg           <= '0;
            use_imm_reg        <= 1'b0;
            imm_reg            <= '0;
            tgt_reg            <= '0;
            flag_reg           <= '0;
            out_valid_reg      <= 1'b0;
            dest_written_reg   <= 1'b0;
            dest_result_reg    <= '0;
            flag_result_reg    <= '0;
            branch_taken_reg   <= 1'b0;
            branch_address_reg <= '0;
            divide_error_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg      <= opcode;
                        dest_reg    <= dest_index;
                        use_imm_reg <= use_immediate;
                        imm_reg     <= immediate_value;
                        tgt_reg     <= jump_target & ADDR_MASK;
                        state_reg   <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (uses_unit)
                    begin
                        state_reg <= S_WAIT;
                    end
                end
                S_WAIT:
                begin
                end
                S_DONE:
                begin
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // commit flag once; the result may have to wait for the slot
            if (finish)
            begin
                flag_reg <= flag_new;
                if (!slot_free)
                begin
                    state_reg <= S_DONE;
                end
            end

            if ((finish || (state_reg == S_DONE)) && slot_free)
            begin
                out_valid_reg      <= 1'b1;
                dest_written_reg   <= wr_now;
                dest_result_reg    <= wr_now ? 32'(alu_result) : '0;
                flag_result_reg    <= 32'(flag_new);
                branch_taken_reg   <= taken;
                branch_address_reg <= taken ? tgt_reg : '0;
                divide_error_reg   <= is_div && alu_rsp.div_zero;
                state_reg          <= S_IDLE;
            end
        end
    end

    assign in_ready       = state_reg == S_IDLE;
    assign out_valid      = out_valid_reg;
    assign dest_written   = dest_written_reg;
    assign dest_result    = dest_result_reg;
    assign flag_result    = flag_result_reg;
    assign branch_taken   = branch_taken_reg;
    assign branch_address = branch_address_reg;
    assign divide_error   = divide_error_reg;

    // one instruction in flight: an accepted transaction blocks the next
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("instruction accepted while another is in flight");

    // ALU completion only while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        alu_rsp.done |-> state_reg == S_WAIT)
        else $error("ALU done outside of wait state");

    // ALU start only from the execute state, never while busy
    a_start_once: assert property (@(posedge clk) disable iff (!rst_n)
        alu_req.start |=> !alu_req.start)
        else $error("ALU started twice in a row");

    // a skipped divide never writes
    a_div_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_error |-> !dest_written && dest_result == '0)
        else $error("divide error with register write");

    // no branch address unless the branch is taken
    a_branch_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !branch_taken |-> branch_address == '0)
        else $error("branch address without taken branch");

endmodule

`default_nettype wire
